[sv/ial_pkg.sv]
// shared types, codes and width constants for the indexed array list
package ial_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int CAPACITY_MAX = 4096;
   // widths fixed by the largest supported capacity
   localparam int LEN_W     = $clog2(CAPACITY_MAX + 1);
   localparam int TOK_POS_W = $clog2(CAPACITY_MAX);

   localparam logic [3:0] FN_FRONT      = 4'd0;
   localparam logic [3:0] FN_END        = 4'd1;
   localparam logic [3:0] FN_INSERT_AT  = 4'd2;
   localparam logic [3:0] FN_GET        = 4'd3;
   localparam logic [3:0] FN_REMOVE     = 4'd4;
   localparam logic [3:0] FN_FIND_FIRST = 4'd5;
   localparam logic [3:0] FN_FIND_LAST  = 4'd6;
   localparam logic [3:0] FN_FIND_MAX   = 4'd7;
   localparam logic [3:0] FN_CLEAR      = 4'd8;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] value;
      logic [8:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [7:0]         position;
      logic               found;
      logic [1:0]         status;
      logic [8:0]         count;
      logic               empty_res;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_HOLD = 2'd0,
      CMD_INS  = 2'd1,
      CMD_REM  = 2'd2
   } cmd_op_type;

   // broadcast to every cell
   typedef struct packed {
      cmd_op_type         op;
      logic [3:0]         func;
      logic [LEN_W-1:0]   at;
      logic signed [31:0] value;
      logic [LEN_W-1:0]   count;
   } cmd_type;

   // search token walking the chain
   typedef struct packed {
      logic                 live;
      logic signed [31:0]   data;
      logic signed [31:0]   best;
      logic [TOK_POS_W-1:0] pos;
      logic                 found;
   } tok_type;

endpackage

[sv/ial_cell.sv]
// one list cell: holds one entry, shifts with its neighbours, updates the search token
module ial_cell #(
   parameter int K = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  ial_pkg::cmd_type   cmd,
   input  logic signed [31:0] left_word,
   input  logic signed [31:0] right_word,
   input  ial_pkg::tok_type   tok_in,
   output logic signed [31:0] word_out,
   output ial_pkg::tok_type   tok_out
);
   import ial_pkg::*;

   localparam logic [LEN_W-1:0]     KPOS = LEN_W'(K);
   localparam logic [TOK_POS_W-1:0] KTOK = TOK_POS_W'(K);

   logic signed [31:0] word_ff, word_in;
   tok_type            tok_ff, tok_in_c;
   logic               active;

   assign active = (KPOS < cmd.count);

   always_comb begin
      word_in = word_ff;
      unique case (cmd.op)
         CMD_INS: begin
            if (KPOS > cmd.at) begin
               word_in = left_word;
            end else if (KPOS == cmd.at) begin
               word_in = cmd.value;
            end
         end
         CMD_REM: begin
            if (KPOS >= cmd.at) begin
               word_in = right_word;
            end
         end
         CMD_HOLD: word_in = word_ff;
         default:  word_in = word_ff;
      endcase
   end

   always_comb begin
      tok_in_c = tok_in;
      if (tok_in.live) begin
         unique case (cmd.func)
            FN_GET, FN_REMOVE: begin
               if (KPOS == cmd.at) begin
                  tok_in_c.data = word_ff;
               end
            end
            FN_FIND_FIRST: begin
               if (active && (word_ff == cmd.value) && !tok_in.found) begin
                  tok_in_c.pos   = KTOK;
                  tok_in_c.found = 1'b1;
               end
            end
            FN_FIND_LAST: begin
               if (active && (word_ff == cmd.value)) begin
                  tok_in_c.pos   = KTOK;
                  tok_in_c.found = 1'b1;
               end
            end
            FN_FIND_MAX: begin
               if (active && ((K == 0) || (word_ff > tok_in.best))) begin
                  tok_in_c.best = word_ff;
                  tok_in_c.pos  = KTOK;
               end
            end
            default: tok_in_c = tok_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_c;
      end
   end

   assign word_out = word_ff;
   assign tok_out  = tok_ff;

endmodule

[sv/indexed_array_list_top.sv]
// top level of the indexed array list: request control and the chain of cells
//
// An ordered list of up to CAPACITY signed 32-bit words held in a row of cells,
// one word per cell. Inserts (front, end, at index) and clear are done in the
// working state: on an insert each cell above the insert point loads from its
// left neighbour in one step and the cell at that point takes the new word;
// clear only resets the count. The result word goes from a result register to
// the output register. Get, remove, find first, find last and find max send a
// search token down the chain, one cell per cycle, so their result waits for
// the walk of the token through every cell; a remove closes the gap with one
// shifting step as the token leaves the chain. One request is worked on at a
// time; the result word sits in an output register, so the next request is
// taken while it waits. Bad indices, a full list and find max on an empty
// list are reported in status and leave the list unchanged.
module indexed_array_list_top #(
   parameter int CAPACITY = ial_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ial_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ial_pkg::rsp_type rsp_data
);
   import ial_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0] count_len, idx_len, at_len, cnt_next;
   logic             is_scan, launch;
   cmd_op_type       op;
   cmd_type          cmd;
   tok_type          tok_head, tok_exit;

   logic signed [31:0] word_w [CAPACITY];
   tok_type            tok_w  [CAPACITY+1];

   assign count_len = LEN_W'(count_ff);
   assign idx_len   = LEN_W'(req_ff.index);

   // insert target, or the index for get and remove
   always_comb begin
      unique case (req_ff.func)
         FN_FRONT: at_len = '0;
         FN_END:   at_len = count_len;
         default:  at_len = idx_len;
      endcase
   end

   assign is_scan = (req_ff.func == FN_GET) || (req_ff.func == FN_REMOVE) ||
                    (req_ff.func == FN_FIND_FIRST) || (req_ff.func == FN_FIND_LAST) ||
                    (req_ff.func == FN_FIND_MAX);

   // control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      op           = CMD_HOLD;
      launch       = 1'b0;
      cnt_next     = count_len;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (is_scan) begin
               launch   = 1'b1;
               state_in = S_SCAN;
            end else begin
               res_in        = '0;
               res_in.status = STAT_OK;
               unique case (req_ff.func)
                  FN_FRONT, FN_END, FN_INSERT_AT: begin
                     priority if (at_len > count_len) begin
                        res_in.status = STAT_RANGE;
                     end else if (count_len >= CAP_LEN) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        op       = CMD_INS;
                        cnt_next = count_len + LEN_W'(1);
                     end
                  end
                  FN_CLEAR: cnt_next = '0;
                  default:  cnt_next = count_len;
               endcase
               res_in.count     = cnt_next[8:0];
               res_in.empty_res = (cnt_next == '0);
               count_in         = cnt_next[CNT_W-1:0];
               state_in         = S_OUT;
            end
         end
         S_SCAN: begin
            if (tok_exit.live) begin
               res_in        = '0;
               res_in.status = STAT_OK;
               unique case (req_ff.func)
                  FN_GET, FN_REMOVE: begin
                     if (idx_len >= count_len) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        res_in.data = tok_exit.data;
                        if (req_ff.func == FN_REMOVE) begin
                           op       = CMD_REM;
                           cnt_next = count_len - LEN_W'(1);
                        end
                     end
                  end
                  FN_FIND_FIRST, FN_FIND_LAST: begin
                     res_in.found    = tok_exit.found;
                     res_in.position = tok_exit.pos[7:0];
                  end
                  FN_FIND_MAX: begin
                     if (count_len == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        res_in.found    = 1'b1;
                        res_in.position = tok_exit.pos[7:0];
                     end
                  end
                  default: res_in.status = STAT_OK;
               endcase
               res_in.count     = cnt_next[8:0];
               res_in.empty_res = (cnt_next == '0);
               count_in         = cnt_next[CNT_W-1:0];
               state_in         = S_OUT;
            end
         end
         S_OUT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // command broadcast to all cells
   assign cmd.op    = op;
   assign cmd.func  = req_ff.func;
   assign cmd.at    = at_len;
   assign cmd.value = req_ff.value;
   assign cmd.count = count_len;

   // fresh token enters the first cell
   assign tok_head.live  = launch;
   assign tok_head.data  = '0;
   assign tok_head.best  = '0;
   assign tok_head.pos   = '0;
   assign tok_head.found = 1'b0;

   assign tok_w[0] = tok_head;
   assign tok_exit = tok_w[CAPACITY];

   // row of cells, each wired to its neighbours; the end cells see zero beyond the row
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [31:0] left_w, right_w;
      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = word_w[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = word_w[k+1];
      end
      ial_cell #(
         .K(k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .tok_in     (tok_w[k]),
         .word_out   (word_w[k]),
         .tok_out    (tok_w[k+1])
      );
   end

endmodule
